>>> sv/lbfit_pkg.sv
// Package with constants and pipeline word types for the letterbox fit extent block.
`timescale 1ns / 1ps
`default_nettype none
package lbfit_pkg;

    // Buffer width alignment; must be a power of two.
    localparam int unsigned ALIGN = 64;

    // Dimension width and number of divider stages (one quotient bit each).
    localparam int unsigned DIM_W = 16;
    localparam int unsigned DIV_STEPS = DIM_W;

    // Word after the multiply stage.
    typedef struct packed {
        logic                   valid;
        logic                   fit;
        logic [DIM_W-1:0]       dst_width;
        logic [DIM_W-1:0]       dst_height;
        logic [DIM_W-1:0]       src_width;
        logic [DIM_W-1:0]       src_height;
        logic [2*DIM_W-1:0]     cross_dst;
        logic [2*DIM_W-1:0]     cross_src;
    } mul_word_t;

    // Word carried through the divider stages.
    typedef struct packed {
        logic                   valid;
        logic                   fit;
        logic                   fit_w;
        logic [DIM_W-1:0]       dst_width;
        logic [DIM_W-1:0]       dst_height;
        logic [DIM_W-1:0]       rem;
        logic [DIM_W-1:0]       num;
        logic [DIM_W-1:0]       den;
        logic [DIM_W-1:0]       quo;
    } div_word_t;

endpackage
`default_nettype wire

>>> sv/letterbox_fit_extent.sv
// Letterbox fit extent: pipelined frame layout with cross-product compare and divider.
//
// Usage: present src_width, src_height, dst_width, dst_height and letterbox
// with in_valid; a word is taken at a clock edge where in_valid is high and
// in_stall is low. Each input word gives exactly one result word on the
// frame, aligned and window ports, taken where out_valid is high and
// out_stall is low.
// The pipeline has one multiply stage, one compare stage, sixteen
// restoring divider stages (one quotient bit each) and one output stage.
// Throughput is one word per cycle while no result is held; most stages are the divider.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated. Empty
// stages hold along with the rest, so bubbles stay where they are.
// Reset (rst_n low, asynchronous) clears all stages; the block is ready
// for input on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module letterbox_fit_extent (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] src_width,
    input  wire logic [15:0] src_height,
    input  wire logic [15:0] dst_width,
    input  wire logic [15:0] dst_height,
    input  wire logic        letterbox,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      frame_width,
    output logic [15:0]      frame_height,
    output logic [16:0]      aligned_width,
    output logic [15:0]      aligned_height,
    output logic [14:0]      valid_x,
    output logic [14:0]      valid_y,
    output logic [15:0]      window_width,
    output logic [15:0]      window_height
);

    localparam int unsigned W = lbfit_pkg::DIM_W;
    localparam int unsigned N = lbfit_pkg::DIV_STEPS;

    logic                   advance;
    lbfit_pkg::mul_word_t   mul_reg;
    lbfit_pkg::mul_word_t   mul_next;
    lbfit_pkg::div_word_t   cmp_next;
    lbfit_pkg::div_word_t   div_reg [0:N];
    lbfit_pkg::div_word_t   div_next [1:N];
    logic                   out_valid_reg;
    logic [15:0]            lw_reg, lh_reg, vw_reg, vh_reg;
    logic [16:0]            bw_reg;
    logic [14:0]            vx_reg, vy_reg;
    logic [15:0]            lw_next, lh_next, vw_next, vh_next;
    logic [16:0]            bw_next;
    logic [14:0]            vx_next, vy_next;
    logic [15:0]            diff_w, diff_h;

    // The pipeline moves unless a valid result is held by the receiver.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Stage one: both cross products.
    always_comb
    begin
        mul_next.valid      = in_valid;
        mul_next.fit        = letterbox && (src_width != '0) && (src_height != '0);
        mul_next.dst_width  = dst_width;
        mul_next.dst_height = dst_height;
        mul_next.src_width  = src_width;
        mul_next.src_height = src_height;
        mul_next.cross_dst  = dst_width * src_height;
        mul_next.cross_src  = src_width * dst_height;
    end

    // Stage two: pick the fitted side and set up the division.
    always_comb
    begin
        cmp_next.valid      = mul_reg.valid;
        cmp_next.fit        = mul_reg.fit;
        cmp_next.fit_w      = mul_reg.cross_dst >= mul_reg.cross_src;
        cmp_next.dst_width  = mul_reg.dst_width;
        cmp_next.dst_height = mul_reg.dst_height;
        cmp_next.quo        = '0;
        if (cmp_next.fit_w)
        begin
            cmp_next.rem = mul_reg.cross_src[2*W-1:W];
            cmp_next.num = mul_reg.cross_src[W-1:0];
            cmp_next.den = mul_reg.src_height;
        end
        else
        begin
            cmp_next.rem = mul_reg.cross_dst[2*W-1:W];
            cmp_next.num = mul_reg.cross_dst[W-1:0];
            cmp_next.den = mul_reg.src_width;
        end
    end

    // Divider stages: one restoring step each. The quotient never exceeds
    // the viewport side, so the upper half of the numerator starts below
    // the divisor and sixteen steps suffice.
    always_comb
    begin
        logic [W:0] trial;
        logic       ge;
        for (int k = 1; k <= N; k++)
        begin
            trial = {div_reg[k-1].rem, div_reg[k-1].num[W-1]};
            ge    = trial >= {1'b0, div_reg[k-1].den};
            div_next[k]     = div_reg[k-1];
            div_next[k].rem = ge ? W'(trial - {1'b0, div_reg[k-1].den}) : trial[W-1:0];
            div_next[k].num = {div_reg[k-1].num[W-2:0], 1'b0};
            div_next[k].quo = {div_reg[k-1].quo[W-2:0], ge};
        end
    end

    // Output stage: window, offsets and aligned buffer width.
    assign diff_w = div_reg[N].dst_width - div_reg[N].quo;
    assign diff_h = div_reg[N].dst_height - div_reg[N].quo;

    always_comb
    begin
        lw_next = div_reg[N].dst_width;
        lh_next = div_reg[N].dst_height;
        bw_next = (17'(div_reg[N].dst_width) + 17'(lbfit_pkg::ALIGN - 1))
                  & ~17'(lbfit_pkg::ALIGN - 1);
        vw_next = div_reg[N].dst_width;
        vh_next = div_reg[N].dst_height;
        vx_next = '0;
        vy_next = '0;
        if (div_reg[N].fit)
        begin
            if (div_reg[N].fit_w)
            begin
                vw_next = div_reg[N].quo;
                vx_next = diff_w[15:1];
            end
            else
            begin
                vh_next = div_reg[N].quo;
                vy_next = diff_h[15:1];
            end
        end
    end

    // Every stage register, valid bits and payload together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= '0;
            for (int k = 0; k <= N; k++)
            begin
                div_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
            lw_reg <= '0;
            lh_reg <= '0;
            bw_reg <= '0;
            vw_reg <= '0;
            vh_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
        end
        else if (advance)
        begin
            mul_reg    <= mul_next;
            div_reg[0] <= cmp_next;
            for (int k = 1; k <= N; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            out_valid_reg <= div_reg[N].valid;
            lw_reg <= lw_next;
            lh_reg <= lh_next;
            bw_reg <= bw_next;
            vw_reg <= vw_next;
            vh_reg <= vh_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_width    = lw_reg;
    assign frame_height   = lh_reg;
    assign aligned_width  = bw_reg;
    assign aligned_height = lh_reg;
    assign valid_x        = vx_reg;
    assign valid_y        = vy_reg;
    assign window_width   = vw_reg;
    assign window_height  = vh_reg;

    // The fitted window never leaves the viewport.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (window_width <= frame_width) && (window_height <= frame_height))
        else $error("fitted window exceeds viewport");

    // Each offset is at most half of the viewport space beside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (16'(valid_x) <= 16'((frame_width - window_width) >> 1))
                   && (16'(valid_y) <= 16'((frame_height - window_height) >> 1)))
        else $error("window offset out of range");

    // A held result keeps the input side stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while result held");

    // The quotient in the last divider stage fits the viewport width when the width is fitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_reg[N].valid && div_reg[N].fit && div_reg[N].fit_w)
            |-> (div_reg[N].quo <= div_reg[N].dst_width))
        else $error("fitted width exceeds viewport width");

endmodule
`default_nettype wire

>>> dv/letterbox_fit_extent_tb.sv
// Self-checking testbench for the letterbox fit extent frame layout block.
`timescale 1ns / 1ps
module letterbox_fit_extent_tb;

    localparam int LATENCY     = 19;
    localparam int NUM_RANDOM  = 1100;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] src_width;
        logic [15:0] src_height;
        logic [15:0] dst_width;
        logic [15:0] dst_height;
        logic        letterbox;
    } request_t;

    typedef struct packed {
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [16:0] aligned_width;
        logic [15:0] aligned_height;
        logic [14:0] valid_x;
        logic [14:0] valid_y;
        logic [15:0] window_width;
        logic [15:0] window_height;
    } layout_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] src_width;
    logic [15:0] src_height;
    logic [15:0] dst_width;
    logic [15:0] dst_height;
    logic        letterbox;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [16:0] aligned_width;
    logic [15:0] aligned_height;
    logic [14:0] valid_x;
    logic [14:0] valid_y;
    logic [15:0] window_width;
    logic [15:0] window_height;

    request_t pending_requests[$];
    layout_t  expected_layouts[$];
    int       mismatch_count;
    int       layouts_checked;
    int       fitted_count;
    int       idle_cycles;
    bit       timed_out;
    bit       quiet_phase;
    bit       hold_sender;
    int       send_gap;
    int       recv_gap;

    letterbox_fit_extent u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .src_width      (src_width),
        .src_height     (src_height),
        .dst_width      (dst_width),
        .dst_height     (dst_height),
        .letterbox      (letterbox),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_width    (frame_width),
        .frame_height   (frame_height),
        .aligned_width  (aligned_width),
        .aligned_height (aligned_height),
        .valid_x        (valid_x),
        .valid_y        (valid_y),
        .window_width   (window_width),
        .window_height  (window_height)
    );

    // Works out the frame layout that one request should produce.
    function automatic layout_t fit_layout(request_t r);
        layout_t     l;
        logic [31:0] cross_dst;
        logic [31:0] cross_src;
        logic [31:0] fitted;
        logic [16:0] aligned;
        l.frame_width    = r.dst_width;
        l.frame_height   = r.dst_height;
        l.aligned_height = r.dst_height;
        aligned = ({1'b0, r.dst_width} + 17'(lbfit_pkg::ALIGN - 1))
                  / 17'(lbfit_pkg::ALIGN) * 17'(lbfit_pkg::ALIGN);
        l.aligned_width = aligned;
        l.valid_x       = '0;
        l.valid_y       = '0;
        l.window_width  = r.dst_width;
        l.window_height = r.dst_height;
        if (r.letterbox && r.src_width != 0 && r.src_height != 0)
        begin
            cross_dst = r.dst_width * r.src_height;
            cross_src = r.src_width * r.dst_height;
            if (cross_dst >= cross_src)
            begin
                fitted = cross_src / r.src_height;
                if (fitted > 32'(r.dst_width))
                    fitted = 32'(r.dst_width);
                l.window_width = fitted[15:0];
                l.valid_x      = 15'((r.dst_width - fitted[15:0]) >> 1);
            end
            else
            begin
                fitted = (r.src_height * r.dst_width) / r.src_width;
                if (fitted > 32'(r.dst_height))
                    fitted = 32'(r.dst_height);
                l.window_height = fitted[15:0];
                l.valid_y       = 15'((r.dst_height - fitted[15:0]) >> 1);
            end
        end
        return l;
    endfunction

    function automatic logic [15:0] random_dim();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'($urandom_range(1, 255));
            2:       return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_request(logic [15:0] sw, logic [15:0] sh,
                               logic [15:0] dw, logic [15:0] dh, logic lb);
        request_t r;
        r.src_width  = sw;
        r.src_height = sh;
        r.dst_width  = dw;
        r.dst_height = dh;
        r.letterbox  = lb;
        pending_requests.push_back(r);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH word %0d %s: got %0d expected %0d",
                 layouts_checked, field, got, want);
        mismatch_count++;
    endtask

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: presents queued requests with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            src_width  <= '0;
            src_height <= '0;
            dst_width  <= '0;
            dst_height <= '0;
            letterbox  <= 1'b0;
            send_gap   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                expected_layouts.push_back(fit_layout({src_width, src_height, dst_width,
                                                       dst_height, letterbox}));
                if (letterbox && src_width != 0 && src_height != 0)
                    fitted_count++;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() == 0 || hold_sender)
                in_valid <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(0, 3);
                in_valid <= 1'b0;
            end
            else
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid   <= 1'b1;
                src_width  <= r.src_width;
                src_height <= r.src_height;
                dst_width  <= r.dst_width;
                dst_height <= r.dst_height;
                letterbox  <= r.letterbox;
            end
        end
    end

    // Monitor: checks each accepted result and drives receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_layouts.size() == 0)
                    report_mismatch("result with no request outstanding", 1, 0);
                else
                begin
                    layout_t e;
                    e = expected_layouts.pop_front();
                    if (frame_width != e.frame_width)
                        report_mismatch("frame_width", frame_width, e.frame_width);
                    if (frame_height != e.frame_height)
                        report_mismatch("frame_height", frame_height, e.frame_height);
                    if (aligned_width != e.aligned_width)
                        report_mismatch("aligned_width", aligned_width, e.aligned_width);
                    if (aligned_height != e.aligned_height)
                        report_mismatch("aligned_height", aligned_height, e.aligned_height);
                    if (valid_x != e.valid_x)
                        report_mismatch("valid_x", valid_x, e.valid_x);
                    if (valid_y != e.valid_y)
                        report_mismatch("valid_y", valid_y, e.valid_y);
                    if (window_width != e.window_width)
                        report_mismatch("window_width", window_width, e.window_width);
                    if (window_height != e.window_height)
                        report_mismatch("window_height", window_height, e.window_height);
                end
                layouts_checked++;
            end
            if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                recv_gap  <= $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        quiet_phase     = 1'b0;
        hold_sender     = 1'b0;

        // Directed: letterbox off, zero source sides, zero viewport sides,
        // extremes, wide and tall sources, clamping and alignment edges.
        add_request(16'd1920, 16'd1080, 16'd640, 16'd480, 1'b0);
        add_request(16'd0, 16'd1080, 16'd640, 16'd480, 1'b1);
        add_request(16'd1920, 16'd0, 16'd640, 16'd480, 1'b1);
        add_request(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        add_request(16'd1920, 16'd1080, 16'd0, 16'd480, 1'b1);
        add_request(16'd1920, 16'd1080, 16'd640, 16'd0, 1'b1);
        add_request(16'd1920, 16'd1080, 16'd640, 16'd480, 1'b1);
        add_request(16'd480, 16'd640, 16'd640, 16'd480, 1'b1);
        add_request(16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1);
        add_request(16'd65535, 16'd1, 16'd65535, 16'd65535, 1'b1);
        add_request(16'd1, 16'd65535, 16'd65535, 16'd65535, 1'b1);
        add_request(16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
        add_request(16'd3, 16'd2, 16'd65535, 16'd2, 1'b1);
        add_request(16'd1, 16'd1, 16'd64, 16'd65, 1'b1);
        add_request(16'd7, 16'd3, 16'd65, 16'd63, 1'b1);
        add_request(16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0);
        add_request(16'd1, 16'd1, 16'd65472, 16'd1, 1'b1);
        add_request(16'd1, 16'd1, 16'd65473, 16'd1, 1'b0);
        add_request(16'd16, 16'd9, 16'd1280, 16'd720, 1'b1);
        wait (pending_requests.size() == 0);

        // Hold the sender until the pipeline has drained.
        hold_sender = 1'b1;
        wait (expected_layouts.size() == 0 && !in_valid);
        hold_sender = 1'b0;

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            add_request(random_dim(), random_dim(), random_dim(), random_dim(),
                        $urandom_range(0, 3) != 0);
            if (i == NUM_RANDOM - 150)
                wait (pending_requests.size() == 0);
        end
        // Last stretch runs with no idling on either side.
        quiet_phase = 1'b1;
        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_layouts.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);

        $display("Checked %0d layout words, %0d of them with an aspect fit.",
                 layouts_checked, fitted_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/lbfit_pkg.sv
sv/letterbox_fit_extent.sv
dv/letterbox_fit_extent_tb.sv
